[sv/finite_difference_gradient_defines.svh]
// Assertion macros shared by the finite difference gradient RTL
`ifndef FINITE_DIFFERENCE_GRADIENT_DEFINES_SVH
`define FINITE_DIFFERENCE_GRADIENT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define FDG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define FDG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/fdg_pkg.sv]
// Shared types, codes and the operation table of the finite difference gradient
package fdg_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_FAULT = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP1,
        S_SETUP2,
        S_OP,
        S_MULW,
        S_DIFF,
        S_DIVST,
        S_DIVW,
        S_EMIT,
        S_AGAIN,
        S_ERR,
        S_SHIFT
    } state_t;

    typedef enum logic [2:0] {
        PH_LEFT,
        PH_MID,
        PH_RIGHT,
        PH_PAIR
    } phase_t;

    // multiply steps; each group is contiguous and ends on a last flag
    typedef enum logic [4:0] {
        ST_T_HLHR,
        ST_DEN,
        ST_HL2,
        ST_HR2,
        ST_S2,
        ST_L_T,
        ST_L_N1,
        ST_L_N2,
        ST_L_N3,
        ST_M_N1,
        ST_M_N2,
        ST_M_N3,
        ST_M_N4,
        ST_R_T,
        ST_R_N1,
        ST_R_N2,
        ST_R_N3
    } step_t;

    typedef enum logic [2:0] {
        M_HL,
        M_HR,
        M_S,
        M_T,
        M_HL2,
        M_HR2,
        M_S2
    } msel_t;

    typedef enum logic [2:0] {
        Q_HL,
        Q_HR,
        Q_S,
        Q_SPHL,
        Q_SPHR,
        Q_FA,
        Q_FB,
        Q_FC
    } qsel_t;

    typedef enum logic [2:0] {
        D_T,
        D_DEN,
        D_HL2,
        D_HR2,
        D_S2,
        D_NUM
    } dst_t;

    typedef enum logic [1:0] {
        A_SET,
        A_NEG,
        A_ADD,
        A_SUB
    } acc_t;

    typedef enum logic [1:0] {
        DS_DEN,
        DS_HL,
        DS_HR
    } dsel_t;

    typedef struct packed {
        msel_t m_sel;
        qsel_t q_sel;
        dst_t  dst;
        acc_t  acc;
        logic  last;
    } op_t;

    typedef struct packed {
        logic  capture;
        logic  setup1;
        logic  setup2;
        logic  mul_start;
        msel_t m_sel;
        qsel_t q_sel;
        logic  mul_write;
        dst_t  dst;
        acc_t  acc;
        logic  diff;
        logic  diff_right;
        logic  div_start;
        dsel_t d_sel;
        logic  emit;
        logic  emit_end;
        logic  emit_err;
        logic  emit_again;
        logic  shift;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic mul_busy;
        logic div_done;
        logic out_free;
        logic eo2;
    } sts_t;

    function automatic op_t op_of(input step_t st);
        op_t o;
        o = '{m_sel: M_HL, q_sel: Q_HR, dst: D_T, acc: A_SET, last: 1'b0};
        unique case (st)
            ST_T_HLHR: o = '{M_HL,  Q_HR,   D_T,   A_SET, 1'b0};
            ST_DEN:    o = '{M_T,   Q_S,    D_DEN, A_SET, 1'b0};
            ST_HL2:    o = '{M_HL,  Q_HL,   D_HL2, A_SET, 1'b0};
            ST_HR2:    o = '{M_HR,  Q_HR,   D_HR2, A_SET, 1'b0};
            ST_S2:     o = '{M_S,   Q_S,    D_S2,  A_SET, 1'b1};
            ST_L_T:    o = '{M_HR,  Q_SPHL, D_T,   A_SET, 1'b0};
            ST_L_N1:   o = '{M_T,   Q_FA,   D_NUM, A_NEG, 1'b0};
            ST_L_N2:   o = '{M_S2,  Q_FB,   D_NUM, A_ADD, 1'b0};
            ST_L_N3:   o = '{M_HL2, Q_FC,   D_NUM, A_SUB, 1'b1};
            ST_M_N1:   o = '{M_HR2, Q_FA,   D_NUM, A_NEG, 1'b0};
            ST_M_N2:   o = '{M_HR2, Q_FB,   D_NUM, A_ADD, 1'b0};
            ST_M_N3:   o = '{M_HL2, Q_FB,   D_NUM, A_SUB, 1'b0};
            ST_M_N4:   o = '{M_HL2, Q_FC,   D_NUM, A_ADD, 1'b1};
            ST_R_T:    o = '{M_HL,  Q_SPHR, D_T,   A_SET, 1'b0};
            ST_R_N1:   o = '{M_HR2, Q_FA,   D_NUM, A_SET, 1'b0};
            ST_R_N2:   o = '{M_S2,  Q_FB,   D_NUM, A_SUB, 1'b0};
            ST_R_N3:   o = '{M_T,   Q_FC,   D_NUM, A_ADD, 1'b1};
            default:   o = '{M_HL,  Q_HR,   D_T,   A_SET, 1'b1};
        endcase
        return o;
    endfunction

endpackage

[sv/fdg_ctrl.sv]
// Sequencer for the finite difference gradient: walks setup, multiplies, divides, emits
module fdg_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          seq_end,
    input  fdg_pkg::sts_t sts,
    output fdg_pkg::cmd_t cmd
);
    import fdg_pkg::*;

    state_t     state_reg, state_next;
    step_t      step_reg, step_next;
    phase_t     phase_reg, phase_next;
    logic [1:0] count_reg, count_next;
    logic       end_reg, end_next;
    logic       diff_reg, diff_next;
    op_t        op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= ST_T_HLHR;
            phase_reg <= PH_MID;
            count_reg <= 2'd0;
            end_reg   <= 1'b0;
            diff_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            phase_reg <= phase_next;
            count_reg <= count_next;
            end_reg   <= end_next;
            diff_reg  <= diff_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        phase_next = phase_reg;
        count_next = count_reg;
        end_next   = end_reg;
        diff_next  = diff_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        op         = op_of(step_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    end_next    = seq_end;
                    state_next  = S_SETUP1;
                end
            end
            S_SETUP1:
            begin
                cmd.setup1 = 1'b1;
                state_next = S_SETUP2;
            end
            S_SETUP2:
            begin
                cmd.setup2 = 1'b1;
                priority if (count_reg == 2'd0)
                    state_next = end_reg ? S_ERR : S_SHIFT;
                else if (count_reg == 2'd1)
                begin
                    priority if (!end_reg)
                        state_next = S_SHIFT;
                    else if (sts.eo2)
                        state_next = S_ERR;
                    else
                    begin
                        phase_next = PH_PAIR;
                        state_next = S_DIFF;
                    end
                end
                else
                begin
                    step_next  = ST_T_HLHR;
                    phase_next = (count_reg == 2'd2) ? PH_LEFT : PH_MID;
                    state_next = S_OP;
                end
            end
            S_OP:
            begin
                cmd.mul_start = 1'b1;
                cmd.m_sel     = op.m_sel;
                cmd.q_sel     = op.q_sel;
                diff_next     = 1'b0;
                state_next    = S_MULW;
            end
            S_MULW:
            begin
                if (sts.mul_done)
                begin
                    cmd.mul_write = 1'b1;
                    cmd.dst       = op.dst;
                    cmd.acc       = op.acc;
                    priority if (!op.last)
                    begin
                        step_next  = step_t'(step_reg + 5'd1);
                        state_next = S_OP;
                    end
                    else if (step_reg == ST_S2)
                    begin
                        // spacing products done: open the interior or order-2 border group, else take the chord
                        priority if (phase_reg == PH_MID)
                        begin
                            step_next  = ST_M_N1;
                            state_next = S_OP;
                        end
                        else if (sts.eo2)
                        begin
                            step_next  = ST_L_T;
                            state_next = S_OP;
                        end
                        else
                            state_next = S_DIFF;
                    end
                    else
                        state_next = S_DIVST;
                end
            end
            S_DIFF:
            begin
                cmd.diff       = 1'b1;
                cmd.diff_right = (phase_reg != PH_LEFT);
                diff_next      = 1'b1;
                state_next     = S_DIVST;
            end
            S_DIVST:
            begin
                cmd.div_start = 1'b1;
                cmd.d_sel     = !diff_reg ? DS_DEN : ((phase_reg == PH_LEFT) ? DS_HL : DS_HR);
                state_next    = S_DIVW;
            end
            S_DIVW:
            begin
                if (sts.div_done)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_end = (phase_reg == PH_RIGHT);
                    unique case (phase_reg)
                        PH_LEFT:
                        begin
                            phase_next = PH_MID;
                            step_next  = ST_M_N1;
                            state_next = S_OP;
                        end
                        PH_MID:
                        begin
                            priority if (!end_reg)
                                state_next = S_SHIFT;
                            else if (sts.eo2)
                            begin
                                phase_next = PH_RIGHT;
                                step_next  = ST_R_T;
                                state_next = S_OP;
                            end
                            else
                            begin
                                phase_next = PH_RIGHT;
                                state_next = S_DIFF;
                            end
                        end
                        PH_RIGHT: state_next = S_SHIFT;
                        PH_PAIR:  state_next = S_AGAIN;
                        default:  state_next = S_SHIFT;
                    endcase
                end
            end
            S_AGAIN:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_again = 1'b1;
                    state_next     = S_SHIFT;
                end
            end
            S_ERR:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_err = 1'b1;
                    count_next   = 2'd0;
                    state_next   = S_IDLE;
                end
            end
            S_SHIFT:
            begin
                cmd.shift  = 1'b1;
                count_next = end_reg ? 2'd0 : ((count_reg == 2'd3) ? 2'd3 : count_reg + 2'd1);
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

[sv/fdg_dp.sv]
// Datapath of the finite difference gradient: history, spacings, serial multiplier, divider
module fdg_dp #(
    parameter int VALUE_WIDTH = fdg_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = fdg_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  fdg_pkg::cmd_t                      cmd,
    output fdg_pkg::sts_t                      sts,
    input  logic                               cfg_we,
    input  logic [fdg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [VALUE_WIDTH-1:0]             cfg_data,
    input  logic signed [VALUE_WIDTH-1:0]      sample_value,
    input  logic signed [VALUE_WIDTH-1:0]      coord_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [VALUE_WIDTH-1:0]      deriv_value,
    output logic                               result_end,
    output logic [1:0]                         status
);
    import fdg_pkg::*;

    localparam int W   = VALUE_WIDTH;
    localparam int HW  = W + 3;                 // spacings and their sums
    localparam int AW  = 3 * W + 4;             // products and numerators
    localparam int DW  = 4 * W + FRAC_BITS + 5; // divider remainder
    localparam int QB  = W + 2;                 // quotient bits, top one flags overflow
    localparam int MCW = $clog2(HW + 1);
    localparam int DCW = $clog2(QB + 1);
    localparam logic [W:0] LIM_POS = {2'b00, {(W-1){1'b1}}};
    localparam logic [W:0] LIM_NEG = {2'b01, {(W-1){1'b0}}};

    // configuration
    logic [1:0]   edge_reg;
    logic         mode_reg;
    logic [W-1:0] ustep_reg;

    // sample history and incoming sample
    logic [W-1:0] fa_reg, fb_reg, xa_reg, xb_reg, fc_reg, xc_reg;

    // spacings
    logic [HW-1:0] hl_reg, hr_reg, s_reg, sphl_reg, sphr_reg;
    logic [HW-1:0] hl_c, hr_c;

    // wide products
    logic [AW-1:0] t_reg, den_reg, hl2_reg, hr2_reg, s2_reg, num_reg;

    // serial multiplier
    logic [AW-1:0]  mc_reg, prod_reg, m_src, mterm, wr_val, diff_c;
    logic [HW-1:0]  mq_reg, q_src;
    logic [MCW-1:0] mcnt_reg;
    logic           mbusy_reg, mlast;

    // restoring divider
    logic [DW-1:0]  r_reg, ysh_reg, x_c, y_c;
    logic [QB-1:0]  q_reg;
    logic [DCW-1:0] dcnt_reg;
    logic           dbusy_reg, neg_reg, zero_reg, ge;
    logic [AW-1:0]  d_src, n_mag, d_mag;

    // result rounding and saturation
    logic [W:0]     lim, q_mag, mag_f, neg_mag;
    logic           sat;
    logic [W-1:0]   val_f;
    logic [1:0]     st_f;

    // output register
    logic           ov_reg, oe_reg;
    logic [W-1:0]   oval_reg;
    logic [1:0]     ost_reg;

    always_comb
    begin
        if (mode_reg)
        begin
            hl_c = {{3{xb_reg[W-1]}}, xb_reg} - {{3{xa_reg[W-1]}}, xa_reg};
            hr_c = {{3{xc_reg[W-1]}}, xc_reg} - {{3{xb_reg[W-1]}}, xb_reg};
        end
        else
        begin
            hl_c = {{3{ustep_reg[W-1]}}, ustep_reg};
            hr_c = {{3{ustep_reg[W-1]}}, ustep_reg};
        end
    end

    always_comb
    begin
        unique case (cmd.m_sel)
            M_HL:    m_src = {{(AW-HW){hl_reg[HW-1]}}, hl_reg};
            M_HR:    m_src = {{(AW-HW){hr_reg[HW-1]}}, hr_reg};
            M_S:     m_src = {{(AW-HW){s_reg[HW-1]}}, s_reg};
            M_T:     m_src = t_reg;
            M_HL2:   m_src = hl2_reg;
            M_HR2:   m_src = hr2_reg;
            M_S2:    m_src = s2_reg;
            default: m_src = '0;
        endcase
        unique case (cmd.q_sel)
            Q_HL:    q_src = hl_reg;
            Q_HR:    q_src = hr_reg;
            Q_S:     q_src = s_reg;
            Q_SPHL:  q_src = sphl_reg;
            Q_SPHR:  q_src = sphr_reg;
            Q_FA:    q_src = {{3{fa_reg[W-1]}}, fa_reg};
            Q_FB:    q_src = {{3{fb_reg[W-1]}}, fb_reg};
            Q_FC:    q_src = {{3{fc_reg[W-1]}}, fc_reg};
            default: q_src = '0;
        endcase
    end

    // two's complement multiplier: the top bit of the multiplier weighs negative
    assign mterm = mq_reg[0] ? mc_reg : '0;
    assign mlast = (mcnt_reg == MCW'(1));

    always_comb
    begin
        unique case (cmd.acc)
            A_SET:   wr_val = prod_reg;
            A_NEG:   wr_val = '0 - prod_reg;
            A_ADD:   wr_val = num_reg + prod_reg;
            A_SUB:   wr_val = num_reg - prod_reg;
            default: wr_val = prod_reg;
        endcase
    end

    always_comb
    begin
        if (cmd.diff_right)
            diff_c = {{(AW-W){fc_reg[W-1]}}, fc_reg} - {{(AW-W){fb_reg[W-1]}}, fb_reg};
        else
            diff_c = {{(AW-W){fb_reg[W-1]}}, fb_reg} - {{(AW-W){fa_reg[W-1]}}, fa_reg};
    end

    // divider set-up: (|N| << (F+1) + |D|) / (2|D|) rounds half away from zero
    always_comb
    begin
        unique case (cmd.d_sel)
            DS_DEN:  d_src = den_reg;
            DS_HL:   d_src = {{(AW-HW){hl_reg[HW-1]}}, hl_reg};
            DS_HR:   d_src = {{(AW-HW){hr_reg[HW-1]}}, hr_reg};
            default: d_src = den_reg;
        endcase
        n_mag = num_reg[AW-1] ? ('0 - num_reg) : num_reg;
        d_mag = d_src[AW-1] ? ('0 - d_src) : d_src;
        x_c   = ({{(DW-AW){1'b0}}, n_mag} << (FRAC_BITS + 1)) + {{(DW-AW){1'b0}}, d_mag};
        y_c   = {{(DW-AW){1'b0}}, d_mag} << (W + 2);
    end

    assign ge = (r_reg >= ysh_reg);

    always_comb
    begin
        lim     = neg_reg ? LIM_NEG : LIM_POS;
        q_mag   = q_reg[W:0];
        sat     = q_reg[QB-1] | (q_mag > lim);
        mag_f   = sat ? lim : q_mag;
        neg_mag = '0 - mag_f;
        priority if (zero_reg)
        begin
            val_f = '0;
            st_f  = ST_FAULT;
        end
        else
        begin
            val_f = neg_reg ? neg_mag[W-1:0] : mag_f[W-1:0];
            st_f  = sat ? ST_FAULT : ST_OK;
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_reg  <= 2'd1;
            mode_reg  <= 1'b0;
            ustep_reg <= {{(W-1){1'b0}}, 1'b1} << FRAC_BITS;
            fa_reg    <= '0;
            fb_reg    <= '0;
            xa_reg    <= '0;
            xb_reg    <= '0;
            mbusy_reg <= 1'b0;
            mcnt_reg  <= '0;
            dbusy_reg <= 1'b0;
            dcnt_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_EDGE:    edge_reg  <= cfg_data[1:0];
                    CFG_SPACING: mode_reg  <= cfg_data[0];
                    CFG_STEP:    ustep_reg <= cfg_data;
                    default:     ;
                endcase
            end
            if (cmd.shift)
            begin
                fa_reg <= fb_reg;
                xa_reg <= xb_reg;
                fb_reg <= fc_reg;
                xb_reg <= xc_reg;
            end
            if (cmd.mul_start)
            begin
                mbusy_reg <= 1'b1;
                mcnt_reg  <= MCW'(HW);
            end
            else if (mbusy_reg)
            begin
                mcnt_reg <= mcnt_reg - MCW'(1);
                if (mlast)
                    mbusy_reg <= 1'b0;
            end
            if (cmd.div_start)
            begin
                dbusy_reg <= 1'b1;
                dcnt_reg  <= DCW'(QB);
            end
            else if (dbusy_reg)
            begin
                dcnt_reg <= dcnt_reg - DCW'(1);
                if (dcnt_reg == DCW'(1))
                    dbusy_reg <= 1'b0;
            end
            priority if (cmd.emit || cmd.emit_err || cmd.emit_again)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            fc_reg <= sample_value;
            xc_reg <= coord_value;
        end
        if (cmd.setup1)
        begin
            hl_reg <= hl_c;
            hr_reg <= hr_c;
        end
        if (cmd.setup2)
        begin
            s_reg    <= hl_reg + hr_reg;
            sphl_reg <= (hl_reg << 1) + hr_reg;
            sphr_reg <= hl_reg + (hr_reg << 1);
        end
        if (cmd.mul_start)
        begin
            mc_reg   <= m_src;
            mq_reg   <= q_src;
            prod_reg <= '0;
        end
        else if (mbusy_reg)
        begin
            prod_reg <= mlast ? (prod_reg - mterm) : (prod_reg + mterm);
            mc_reg   <= mc_reg << 1;
            mq_reg   <= mq_reg >> 1;
        end
        if (cmd.mul_write)
        begin
            unique case (cmd.dst)
                D_T:     t_reg   <= wr_val;
                D_DEN:   den_reg <= wr_val;
                D_HL2:   hl2_reg <= wr_val;
                D_HR2:   hr2_reg <= wr_val;
                D_S2:    s2_reg  <= wr_val;
                D_NUM:   num_reg <= wr_val;
                default: ;
            endcase
        end
        else if (cmd.diff)
            num_reg <= diff_c;
        if (cmd.div_start)
        begin
            r_reg    <= x_c;
            ysh_reg  <= y_c;
            q_reg    <= '0;
            neg_reg  <= num_reg[AW-1] ^ d_src[AW-1];
            zero_reg <= (d_src == '0);
        end
        else if (dbusy_reg)
        begin
            if (ge)
                r_reg <= r_reg - ysh_reg;
            q_reg   <= {q_reg[QB-2:0], ge};
            ysh_reg <= ysh_reg >> 1;
        end
        priority if (cmd.emit)
        begin
            oval_reg <= val_f;
            ost_reg  <= st_f;
            oe_reg   <= cmd.emit_end;
        end
        else if (cmd.emit_err)
        begin
            oval_reg <= '0;
            ost_reg  <= ST_SHORT;
            oe_reg   <= 1'b1;
        end
        else if (cmd.emit_again)
            oe_reg <= 1'b1;
    end

    assign sts.mul_done = !mbusy_reg;
    assign sts.mul_busy = mbusy_reg;
    assign sts.div_done = !dbusy_reg;
    assign sts.out_free = !ov_reg || out_ready;
    assign sts.eo2      = edge_reg[1];

    assign out_valid   = ov_reg;
    assign deriv_value = oval_reg;
    assign result_end  = oe_reg;
    assign status      = ost_reg;

endmodule

[sv/finite_difference_gradient.sv]
// Top level of the streaming finite difference gradient
// Takes one sample request at a time and emits the first derivative at every position of a
// 1-D sequence in signed Q(VALUE_WIDTH-FRAC_BITS).FRAC_BITS, interior points by second-order
// central weights, borders by a one-sided chord or a three-point stencil. Each result is one
// exact ratio N/D built from a single shift-add multiplier and rounded by a restoring divider.
// An interior sample costs 9 products and one division; the third sample of a sequence with
// order-2 borders costs 13 products and two divisions, and so does a later final sample.
// The longest case is a three-sample sequence with order-2 borders: its last sample costs
// 17 products and three divisions. The multiplier is the limiting unit.
// A sample is taken only while the sequencer is idle; the last result of a sample may still
// sit in the output register while the next sample request is taken. Configuration writes
// land at once and must only be made between items.
`include "finite_difference_gradient_defines.svh"

module finite_difference_gradient #(
    parameter int VALUE_WIDTH = fdg_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = fdg_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [fdg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [VALUE_WIDTH-1:0]         cfg_data,
    // sample requests
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [VALUE_WIDTH-1:0]  sample_value,
    input  logic signed [VALUE_WIDTH-1:0]  coord_value,
    input  logic                           seq_end,
    // derivative results
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [VALUE_WIDTH-1:0]  deriv_value,
    output logic                           result_end,
    output logic [1:0]                     status
);
    import fdg_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer: decides which border or interior stencil runs and when results leave
    fdg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .seq_end  (seq_end),
        .sts      (sts),
        .cmd      (cmd)
    );

    // arithmetic, history and the output register
    fdg_dp #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_value (sample_value),
        .coord_value  (coord_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .deriv_value  (deriv_value),
        .result_end   (result_end),
        .status       (status)
    );

    // a taken sample keeps the sequencer busy for at least the set-up cycles
    `FDG_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready, "request taken twice")
    // no sample is taken while a product is being formed
    `FDG_ASSERT_NOW(a_mul_blocks_input, sts.mul_busy, !in_ready, "input open during multiply")
    // a short-sequence error is always the closing result and carries zero
    `FDG_ASSERT_NOW(a_short_is_final, out_valid && status == ST_SHORT, result_end && deriv_value == '0, "malformed short-sequence result")

endmodule

[bench/gradient_checker.sv]
// Checker for the finite difference gradient: snoops every port, predicts and compares results
module gradient_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [31:0] sample_value,
    input  logic [31:0] coord_value,
    input  logic        seq_end,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] deriv_value,
    input  logic        result_end,
    input  logic [1:0]  status,
    output int          fail_count,
    output int          pending,
    output int          deriv_seen
);
    import fdg_pkg::*;

    typedef logic signed [255:0] wide_t;

    typedef struct packed {
        logic [31:0] value;
        logic        last;
        logic [1:0]  code;
    } deriv_t;

    deriv_t      deriv_q[$];
    logic [1:0]  edge_ord;
    logic        coord_mode;
    logic [31:0] step_h;
    logic [31:0] f_old, f_new, x_old, x_new;
    int          seen;

    assign pending = deriv_q.size();

    function automatic wide_t sx(input logic [31:0] x);
        return wide_t'(signed'(x));
    endfunction

    function automatic wide_t gap(input logic [31:0] xa, input logic [31:0] xb);
        return coord_mode ? sx(xb) - sx(xa) : sx(step_h);
    endfunction

    // exact N/D rounded half away from zero, saturated
    function automatic void push_ratio(input wide_t n, input wide_t d, input logic last);
        deriv_t r;
        wide_t  an, ad, q, lim;
        logic   neg;
        r.last = last;
        r.code = ST_OK;
        if (d == 0)
        begin
            r.value = '0;
            r.code  = ST_FAULT;
        end
        else
        begin
            neg = n[255] != d[255];
            an  = n[255] ? -n : n;
            ad  = d[255] ? -d : d;
            q   = ((an <<< 17) + ad) / (ad + ad);
            lim = neg ? wide_t'(64'h8000_0000) : wide_t'(64'h7fff_ffff);
            if (q > lim)
            begin
                q      = lim;
                r.code = ST_FAULT;
            end
            r.value = neg ? -q[31:0] : q[31:0];
        end
        deriv_q.insert(deriv_q.size(), r);
    endfunction

    function automatic void push_short();
        deriv_t r;
        r.value = '0;
        r.last  = 1'b1;
        r.code  = ST_SHORT;
        deriv_q.insert(deriv_q.size(), r);
    endfunction

    function automatic void take_sample(input logic [31:0] fv, input logic [31:0] xv,
                                        input logic e);
        logic  eo2;
        wide_t fa, fb, fc, hl, hr, s, hl2, hr2, s2, den, n;
        eo2 = edge_ord >= 2;
        if (seen == 0)
        begin
            if (e) push_short();
            else
            begin
                f_new = fv; x_new = xv; seen = 1;
            end
        end
        else if (seen == 1)
        begin
            if (e)
            begin
                if (eo2) push_short();
                else
                begin
                    n  = sx(fv) - sx(f_new);
                    hr = gap(x_new, xv);
                    push_ratio(n, hr, 1'b0);
                    push_ratio(n, hr, 1'b1);
                end
                seen = 0;
            end
            else
            begin
                f_old = f_new; x_old = x_new; f_new = fv; x_new = xv; seen = 2;
            end
        end
        else
        begin
            fa = sx(f_old); fb = sx(f_new); fc = sx(fv);
            hl = gap(x_old, x_new);
            hr = gap(x_new, xv);
            s = hl + hr;
            hl2 = hl * hl; hr2 = hr * hr; s2 = s * s;
            den = hl * hr * s;
            // left border, only once per sequence
            if (seen == 2)
            begin
                if (eo2) push_ratio(-((s + hl) * hr * fa) + s2 * fb - hl2 * fc, den, 1'b0);
                else     push_ratio(fb - fa, hl, 1'b0);
            end
            push_ratio(-(hr2 * fa) + (hr2 - hl2) * fb + hl2 * fc, den, 1'b0);
            if (e)
            begin
                if (eo2) push_ratio(hr2 * fa - s2 * fb + (s + hr) * hl * fc, den, 1'b1);
                else     push_ratio(fc - fb, hr, 1'b1);
                seen = 0;
            end
            else seen = 3;
            f_old = f_new; x_old = x_new; f_new = fv; x_new = xv;
        end
    endfunction

    always @(posedge clk)
    begin
        deriv_t want;
        if (!rst_n)
        begin
            edge_ord = 2'd1; coord_mode = 1'b0; step_h = 32'h0001_0000;
            f_old = '0; f_new = '0; x_old = '0; x_new = '0; seen = 0;
            deriv_q.delete();
            fail_count = 0;
            deriv_seen = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_EDGE)    edge_ord   = cfg_data[1:0];
                if (cfg_index == CFG_SPACING) coord_mode = cfg_data[0];
                if (cfg_index == CFG_STEP)    step_h     = cfg_data;
            end
            if (in_valid && in_ready)
                take_sample(sample_value, coord_value, seq_end);
            if (out_valid && out_ready)
            begin
                deriv_seen++;
                if (deriv_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %h end %b status %0d",
                                 deriv_value, result_end, status);
                end
                else
                begin
                    want = deriv_q.pop_front();
                    if (want.value !== deriv_value || want.last !== result_end
                        || want.code !== status)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("result mismatch: exp %h/%b/%0d got %h/%b/%0d",
                                     want.value, want.last, want.code,
                                     deriv_value, result_end, status);
                    end
                end
            end
        end
    end

endmodule

[bench/tb_top.sv]
// Top of the finite difference gradient testbench: stimulus, idling, watchdog and verdict
module tb_top;
    import fdg_pkg::*;

    localparam int WATCHDOG = 40000; // idle cycles before we give up
    localparam int SETTLE   = 1000;  // covers the longest sample in flight

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_EDGE;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] sample_value = '0;
    logic [31:0] coord_value = '0;
    logic        seq_end = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] deriv_value;
    logic        result_end;
    logic [1:0]  status;

    int fail_count, pending, deriv_seen;
    int tx_idle, rx_idle;      // idle percentages
    int sent, settings_run;
    int stall_cycles = 0;
    logic [31:0] x_run;        // running coordinate

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    finite_difference_gradient u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .sample_value(sample_value), .coord_value(coord_value), .seq_end(seq_end),
        .out_valid(out_valid), .out_ready(out_ready),
        .deriv_value(deriv_value), .result_end(result_end), .status(status)
    );

    gradient_checker u_chk (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .sample_value(sample_value), .coord_value(coord_value), .seq_end(seq_end),
        .out_valid(out_valid), .out_ready(out_ready),
        .deriv_value(deriv_value), .result_end(result_end), .status(status),
        .fail_count(fail_count), .pending(pending), .deriv_seen(deriv_seen)
    );

    // receiver back-pressure, redrawn every cycle
    always @(posedge clk)
        if (rst_n) out_ready <= ($urandom_range(99) >= rx_idle);

    // watchdog: cycles without any request moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG)
        begin
            $display("watchdog expired, %0d results outstanding", pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    // one sample request; valid stays up into the next call unless a gap is drawn
    task automatic send_sample(input logic [31:0] f, input logic [31:0] x, input logic e);
        logic rdy;
        if ($urandom_range(99) < tx_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < tx_idle) @(posedge clk);
        end
        in_valid     <= 1'b1;
        sample_value <= f;
        coord_value  <= x;
        seq_end      <= e;
        do
        begin
            @(negedge clk);
            rdy = in_ready;
            @(posedge clk);
        end
        while (!rdy);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // registers change only with the block drained
    task automatic set_regs(input logic [1:0] ord, input logic mode, input logic [31:0] h);
        drain();
        cfg_we <= 1'b1; cfg_index <= CFG_EDGE;    cfg_data <= {30'd0, ord};
        @(posedge clk);
        cfg_index <= CFG_SPACING; cfg_data <= {31'd0, mode};
        @(posedge clk);
        cfg_index <= CFG_STEP;    cfg_data <= h;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_run++;
    endtask

    function automatic logic [31:0] rand_value();
        if ($urandom_range(9) < 7) return $urandom_range(32'h0020_0000) - 32'h0010_0000;
        return $urandom;
    endfunction

    // coordinates mostly climb; now and then they stall, step back or jump anywhere
    function automatic logic [31:0] next_coord();
        int pick;
        pick = $urandom_range(19);
        if (pick == 0)      x_run = x_run;
        else if (pick == 1) x_run = x_run - $urandom_range(32'h0004_0000, 32'h1000);
        else if (pick == 2) x_run = $urandom;
        else                x_run = x_run + $urandom_range(32'h0004_0000, 32'h1000);
        return x_run;
    endfunction

    task automatic random_sequence();
        int len;
        len = ($urandom_range(9) == 0) ? $urandom_range(2, 1) : $urandom_range(8, 3);
        for (int k = 0; k < len; k++)
            send_sample(rand_value(), next_coord(), k == len - 1);
    endtask

    function automatic logic [31:0] rand_step();
        case ($urandom_range(5))
            0:       return 32'h0001_0000;
            1:       return $urandom;
            2:       return -$urandom_range(32'h0004_0000, 32'h100);
            default: return $urandom_range(32'h0004_0000, 32'h100);
        endcase
    endfunction

    initial
    begin
        tx_idle = 19; rx_idle = 54;
        sent = 0; settings_run = 0; x_run = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: order-1 borders, unit step
        send_sample(32'h0001_0000, 32'h0, 1'b1);                 // lone sample
        send_sample(32'h0000_0000, 32'h0, 1'b0);                 // two-sample chord
        send_sample(32'h0003_0000, 32'h0, 1'b1);
        send_sample(32'h7fff_ffff, 32'hffff_ffff, 1'b0);          // saturating extremes
        send_sample(32'h8000_0000, 32'h0, 1'b0);
        send_sample(32'h7fff_ffff, 32'h8000_0000, 1'b1);

        // order-2 borders: too-short pair, then a three-sample run
        set_regs(2'd2, 1'b0, 32'h0001_0000);
        send_sample(32'h0001_0000, 32'h0, 1'b0);
        send_sample(32'h0002_0000, 32'h0, 1'b1);
        send_sample(32'h0000_0000, 32'h0, 1'b0);
        send_sample(32'h0001_0000, 32'h0, 1'b0);
        send_sample(32'h0004_0000, 32'h0, 1'b1);

        // coordinates: uneven, repeated (zero gap), and gaps that cancel
        set_regs(2'd3, 1'b1, 32'h0001_0000);
        send_sample(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_sample(32'h0001_0000, 32'h0001_0000, 1'b0);
        send_sample(32'h0004_0000, 32'h0003_0000, 1'b0);
        send_sample(32'h0009_0000, 32'h0003_0000, 1'b1);
        send_sample(32'h0001_0000, 32'h0000_0000, 1'b0);
        send_sample(32'h0002_0000, 32'h0001_0000, 1'b0);
        send_sample(32'h0003_0000, 32'h0000_0000, 1'b1);

        // zero step, then the most negative step with order 0 borders
        set_regs(2'd1, 1'b0, 32'h0000_0000);
        send_sample(32'h0001_0000, 32'h0, 1'b0);
        send_sample(32'h0002_0000, 32'h0, 1'b1);
        set_regs(2'd0, 1'b0, 32'h8000_0000);
        send_sample(32'h8000_0000, 32'h0, 1'b0);
        send_sample(32'h7fff_ffff, 32'h0, 1'b0);
        send_sample(32'h0000_0001, 32'h0, 1'b1);

        // random phase: fresh settings every few sequences
        while (sent < 300)
        begin
            if (sent > 100 && tx_idle == 19)
            begin
                tx_idle = 54; rx_idle = 19;
            end
            else if (sent > 200 && tx_idle == 54)
            begin
                tx_idle = 0; rx_idle = 0;
            end
            if (settings_run == 6)
            begin
                // hold the sender until every result is home, mid-sequence
                send_sample(rand_value(), next_coord(), 1'b0);
                send_sample(rand_value(), next_coord(), 1'b0);
                send_sample(rand_value(), next_coord(), 1'b0);
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
                send_sample(rand_value(), next_coord(), 1'b1);
            end
            set_regs($urandom_range(3), $urandom_range(1), rand_step());
            repeat ($urandom_range(6, 2)) random_sequence();
        end

        drain();
        $display("%0d samples sent under %0d register settings, %0d derivatives checked",
                 sent, settings_run, deriv_seen);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/fdg_pkg.sv
sv/fdg_ctrl.sv
sv/fdg_dp.sv
sv/finite_difference_gradient.sv
bench/gradient_checker.sv
bench/tb_top.sv
